/* hdl/cac_pkg.sv */
`default_nettype none
package cac_pkg;

    localparam int CAP_SLOTS_DEF    = 16;
    localparam int REGION_SLOTS_DEF = 8;

    localparam int IN_DATA_W  = 240;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;
    localparam int SLOT_W     = 4;

    localparam logic [1:0] REQ_GRANT     = 2'd0;
    localparam logic [1:0] REQ_LOAD      = 2'd1;
    localparam logic [1:0] REQ_CHECK_CAP = 2'd2;
    localparam logic [1:0] REQ_CHECK_MEM = 2'd3;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_FULL     = 2'd1;
    localparam logic [1:0] STS_INACTIVE = 2'd2;

    localparam logic REG_TOKEN_ACTIVE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CAP,
        ST_REG,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic cap_step;
        logic reg_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic need_cap;
        logic need_reg;
        logic cap_end;
        logic reg_end;
        logic out_free;
    } sts_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage
`default_nettype wire

/* hdl/cac_ctrl.sv */
`default_nettype none
module cac_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output cac_pkg::cmd_t      cmd,
    input  wire cac_pkg::sts_t sts
);

    cac_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cac_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cac_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = cac_pkg::ST_CAP;
            end
            cac_pkg::ST_CAP: begin
                // first cycle after load also lands here; skip when no walk is needed
                if (!sts.need_cap || sts.cap_end) begin
                    state_next = sts.need_reg ? cac_pkg::ST_REG : cac_pkg::ST_FIN;
                end
            end
            cac_pkg::ST_REG: begin
                if (sts.reg_end) state_next = cac_pkg::ST_FIN;
            end
            cac_pkg::ST_FIN: begin
                if (sts.out_free) state_next = cac_pkg::ST_IDLE;
            end
            default: state_next = cac_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == cac_pkg::ST_IDLE);
        cmd.load     = (state_reg == cac_pkg::ST_IDLE) && s_tvalid;
        cmd.cap_step = (state_reg == cac_pkg::ST_CAP) && sts.need_cap;
        cmd.reg_step = (state_reg == cac_pkg::ST_REG);
        cmd.emit     = (state_reg == cac_pkg::ST_FIN) && sts.out_free;
    end

endmodule
`default_nettype wire

/* hdl/cac_dp.sv */
`default_nettype none
module cac_dp #(
    parameter int CAP_SLOTS    = cac_pkg::CAP_SLOTS_DEF,
    parameter int REGION_SLOTS = cac_pkg::REGION_SLOTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire cac_pkg::cmd_t                   cmd,
    output cac_pkg::sts_t                        sts,
    input  wire logic                            token_active,
    input  wire logic [cac_pkg::IN_USER_W-1:0]   s_tuser,
    input  wire logic [cac_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [cac_pkg::OUT_DATA_W-1:0]       m_tdata
);

    localparam int CW  = $clog2(CAP_SLOTS + 1);
    localparam int CIW = (CAP_SLOTS > 1) ? $clog2(CAP_SLOTS) : 1;
    localparam int RW  = $clog2(REGION_SLOTS + 1);
    localparam int RIW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

    // unpack request
    logic [1:0]  in_req;
    logic [15:0] in_mask, in_res;
    logic [31:0] in_limit, in_len;
    logic [47:0] in_expiry, in_addr, in_now;
    assign in_req    = s_tuser[1:0];
    assign in_mask   = s_tdata[15:0];
    assign in_res    = s_tdata[31:16];
    assign in_limit  = s_tdata[63:32];
    assign in_expiry = s_tdata[111:64];
    assign in_addr   = s_tdata[159:112];
    assign in_len    = s_tdata[191:160];
    assign in_now    = s_tdata[239:192];

    // tables
    logic [CAP_SLOTS-1:0] cap_live_reg;
    logic [15:0]          cap_tmask_reg  [CAP_SLOTS];
    logic [15:0]          cap_res_reg    [CAP_SLOTS];
    logic [31:0]          cap_limit_reg  [CAP_SLOTS];
    logic [31:0]          cap_uses_reg   [CAP_SLOTS];
    logic [47:0]          cap_expiry_reg [CAP_SLOTS];
    logic [CW-1:0]        cap_fill_reg;

    logic [47:0]          reg_base_reg [REGION_SLOTS];
    logic [31:0]          reg_len_reg  [REGION_SLOTS];
    logic [15:0]          reg_perm_reg [REGION_SLOTS];
    logic [RW-1:0]        reg_fill_reg;

    logic [31:0] viol_reg, total_reg;

    // per-request working registers
    logic [1:0]  req_reg;
    logic [15:0] mask_reg, cres_reg;
    logic [47:0] addr_reg, now_reg;
    logic [31:0] len_reg;
    logic [CW-1:0]  cap_idx_reg;
    logic [RW-1:0]  reg_idx_reg;
    logic [CIW-1:0] cslot_reg;
    logic [RIW-1:0] rslot_reg;
    logic [CIW-1:0] wslot_reg;
    logic           by_cap_reg, by_reg_reg;
    logic [1:0]     status_reg;
    logic           need_cap_reg, need_reg_reg;
    logic           m_valid_reg;
    logic [cac_pkg::OUT_DATA_W-1:0] m_data_reg;

    // capability walk evaluation
    logic [CIW-1:0] ci;
    logic           c_in_range, c_expired, c_match, c_hit, c_over;
    assign ci         = cap_idx_reg[CIW-1:0];
    assign c_in_range = cap_idx_reg < CW'(CAP_SLOTS) && cap_idx_reg < cap_fill_reg;
    assign c_expired  = (cap_expiry_reg[ci] != 48'd0) && (now_reg > cap_expiry_reg[ci]);
    assign c_match    = ((cap_tmask_reg[ci] & mask_reg) != 16'd0) &&
                        (cres_reg == 16'd0 || cap_res_reg[ci] == 16'd0 ||
                         cap_res_reg[ci] == cres_reg);
    assign c_hit      = c_in_range && cap_live_reg[ci] && !c_expired && c_match;
    assign c_over     = (cap_limit_reg[ci] != 32'd0) && (cap_uses_reg[ci] >= cap_limit_reg[ci]);

    // region walk evaluation: base <= addr and addr + len <= base + rlen, no wrap
    logic [RIW-1:0] ri;
    logic           r_in_range, r_hit;
    logic [48:0]    r_end_acc, r_end_reg;
    assign ri         = reg_idx_reg[RIW-1:0];
    assign r_in_range = reg_idx_reg < RW'(REGION_SLOTS) && reg_idx_reg < reg_fill_reg;
    assign r_end_acc  = {1'b0, addr_reg} + {17'd0, len_reg};
    assign r_end_reg  = {1'b0, reg_base_reg[ri]} + {17'd0, reg_len_reg[ri]};
    assign r_hit      = r_in_range && ((reg_perm_reg[ri] & mask_reg) != 16'd0) &&
                        (addr_reg >= reg_base_reg[ri]) && (r_end_acc <= r_end_reg);

    always_comb begin
        sts.need_cap = need_cap_reg;
        sts.need_reg = need_reg_reg;
        sts.cap_end  = !c_in_range || c_hit;
        sts.reg_end  = !r_in_range || r_hit;
        sts.out_free = !m_valid_reg || m_tready;
    end

    // table storage and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_live_reg <= '0;
            cap_fill_reg <= '0;
            reg_fill_reg <= '0;
            viol_reg     <= '0;
            total_reg    <= '0;
        end else begin
            if (cmd.load) begin
                if (in_req == cac_pkg::REQ_GRANT && token_active &&
                    cap_fill_reg < CW'(CAP_SLOTS)) begin
                    cap_live_reg[cap_fill_reg[CIW-1:0]] <= 1'b1;
                    cap_fill_reg <= cap_fill_reg + CW'(1);
                end
                if (in_req == cac_pkg::REQ_LOAD && reg_fill_reg < RW'(REGION_SLOTS)) begin
                    reg_fill_reg <= reg_fill_reg + RW'(1);
                end
                if (in_req[1] && token_active) total_reg <= cac_pkg::sat_inc32(total_reg);
            end
            if (cmd.cap_step) begin
                if (c_in_range && cap_live_reg[ci] && c_expired) cap_live_reg[ci] <= 1'b0;
                // no entry found, or entry over its limit
                if (!c_in_range || (c_hit && c_over)) viol_reg <= cac_pkg::sat_inc32(viol_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && in_req == cac_pkg::REQ_GRANT && token_active &&
            cap_fill_reg < CW'(CAP_SLOTS)) begin
            cap_tmask_reg[cap_fill_reg[CIW-1:0]]  <= in_mask;
            cap_res_reg[cap_fill_reg[CIW-1:0]]    <= in_res;
            cap_limit_reg[cap_fill_reg[CIW-1:0]]  <= in_limit;
            cap_expiry_reg[cap_fill_reg[CIW-1:0]] <= in_expiry;
            cap_uses_reg[cap_fill_reg[CIW-1:0]]   <= 32'd0;
        end else if (cmd.cap_step && c_hit && cap_limit_reg[ci] != 32'd0) begin
            cap_uses_reg[ci] <= cac_pkg::sat_inc32(cap_uses_reg[ci]);
        end
        if (cmd.load && in_req == cac_pkg::REQ_LOAD && reg_fill_reg < RW'(REGION_SLOTS)) begin
            reg_base_reg[reg_fill_reg[RIW-1:0]] <= in_addr;
            reg_len_reg[reg_fill_reg[RIW-1:0]]  <= in_len;
            reg_perm_reg[reg_fill_reg[RIW-1:0]] <= in_mask;
        end
    end

    // request working state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            need_cap_reg <= 1'b0;
            need_reg_reg <= 1'b0;
        end else if (cmd.load) begin
            need_cap_reg <= in_req[1] && token_active;
            need_reg_reg <= (in_req == cac_pkg::REQ_CHECK_MEM) && (in_addr != 48'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg       <= in_req;
            mask_reg      <= in_mask;
            cres_reg      <= (in_req == cac_pkg::REQ_CHECK_CAP) ? in_res : 16'd0;
            addr_reg      <= in_addr;
            len_reg       <= in_len;
            now_reg       <= in_now;
            cap_idx_reg   <= '0;
            reg_idx_reg   <= '0;
            cslot_reg     <= '0;
            rslot_reg     <= '0;
            by_cap_reg    <= 1'b0;
            by_reg_reg    <= 1'b0;
            wslot_reg     <= '0;
            status_reg    <= cac_pkg::STS_OK;
            if (in_req == cac_pkg::REQ_GRANT) begin
                if (!token_active) status_reg <= cac_pkg::STS_INACTIVE;
                else if (cap_fill_reg >= CW'(CAP_SLOTS)) status_reg <= cac_pkg::STS_FULL;
                else wslot_reg <= cap_fill_reg[CIW-1:0];
            end else if (in_req == cac_pkg::REQ_LOAD) begin
                if (reg_fill_reg >= RW'(REGION_SLOTS)) status_reg <= cac_pkg::STS_FULL;
            end else if (!token_active) begin
                status_reg <= cac_pkg::STS_INACTIVE;
            end
        end
        if (cmd.cap_step) begin
            cap_idx_reg <= cap_idx_reg + CW'(1);
            if (c_hit) begin
                cslot_reg  <= ci;
                by_cap_reg <= !c_over;
            end
        end
        if (cmd.reg_step) begin
            reg_idx_reg <= reg_idx_reg + RW'(1);
            if (r_hit) begin
                rslot_reg  <= ri;
                by_reg_reg <= 1'b1;
            end
        end
    end

    // region load slot is the old fill count, known only for loads
    logic [RIW-1:0] lslot_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load) lslot_reg <= (reg_fill_reg < RW'(REGION_SLOTS)) ?
                                   reg_fill_reg[RIW-1:0] : '0;
    end

    // result slot, low four bits
    logic [CIW+3:0] cslot_w, wslot_w;
    logic [RIW+3:0] rslot_w, lslot_w;
    logic [3:0]     slot;
    assign cslot_w = {4'd0, cslot_reg};
    assign wslot_w = {4'd0, wslot_reg};
    assign rslot_w = {4'd0, rslot_reg};
    assign lslot_w = {4'd0, lslot_reg};

    always_comb begin
        priority if (req_reg == cac_pkg::REQ_GRANT) slot = wslot_w[3:0];
        else if (req_reg == cac_pkg::REQ_LOAD) slot = lslot_w[3:0];
        else if (by_cap_reg || !by_reg_reg) slot = cslot_w[3:0];
        else slot = rslot_w[3:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {7'd0, total_reg, viol_reg, slot, status_reg,
                           by_reg_reg, by_cap_reg, by_cap_reg | by_reg_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

/* hdl/capability_access_checker_core.sv */
`default_nettype none
// Capability access checker.
// Input channel (s_): one request per handshake. s_tuser carries the request
// kind (grant capability, load region, check capability, check memory access),
// s_tdata the operands. Output channel (m_): exactly one result per request,
// in order: granted, by_capability, by_region, status, matched_slot and the
// saturating violation and check totals.
// Configuration: APB register 0 (address 0) holds token_active, reset 1.
// Sequence: a grant or load passes through the capability and finish states
// without a walk. A check visits capability entries in turn, the probe past
// the last filled entry included (up to CAP_SLOTS+1; the walk is skipped
// while the token is inactive), then region entries (up to REGION_SLOTS+1)
// for a memory check with a nonzero address, and then emits its result. The
// next request is accepted in the same cycle as the result appears in the
// output register.
// One request is in flight at a time; s_tready is high while the controller
// waits for a request, also while a result sits in the output register.
// If the receiver stalls, the result holds in the output register and the
// next request is walked; its result waits until the register frees.
// Reset empties both tables, clears counters and sets token_active.
module capability_access_checker_core #(
    parameter int CAP_SLOTS    = cac_pkg::CAP_SLOTS_DEF,
    parameter int REGION_SLOTS = cac_pkg::REGION_SLOTS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // req_type[1:0]
    input  wire logic [cac_pkg::IN_USER_W-1:0]     s_tuser,
    // type_mask[15:0] resource_id[31:16] use_limit[63:32] expiry[111:64]
    // address[159:112] length[191:160] now[239:192]
    input  wire logic [cac_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // granted[0] by_capability[1] by_region[2] status[4:3] matched_slot[8:5]
    // violation_total[40:9] access_total[72:41], zero pad [79:73]
    output logic [cac_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    logic          token_reg;
    cac_pkg::cmd_t cmd;
    cac_pkg::sts_t sts;

    // register write on the APB access phase
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == cac_pkg::REG_TOKEN_ACTIVE) begin
            token_reg <= pwdata[0];
        end
    end
    assign prdata = (paddr[2] == cac_pkg::REG_TOKEN_ACTIVE) ? {31'd0, token_reg} : 32'd0;

    cac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    cac_dp #(
        .CAP_SLOTS    (CAP_SLOTS),
        .REGION_SLOTS (REGION_SLOTS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .token_active (token_reg),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    // granted is exactly the OR of its two sources
    a_grant_src: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[1] | m_tdata[2])))
        else $error("granted does not match its sources");

    // an inactive token never lets a capability grant
    a_inactive_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4:3] == cac_pkg::STS_INACTIVE) |-> !m_tdata[1])
        else $error("capability grant while token inactive");

    // status code three is never produced
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:3] != 2'd3))
        else $error("undefined status code");

    // violation count never decreases
    a_viol_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && $past(m_tvalid) && $past(aresetn) && $past(aresetn, 2)) |->
        (m_tdata[40:9] >= $past(m_tdata[40:9])))
        else $error("violation total went down");

endmodule
`default_nettype wire
